>>> rtl/bvg_pkg.sv
// bvg_pkg: widths, scaling constants, sequencer states and the charge level table
// for the battery voltage gauge
// no dependencies
package bvg_pkg;

  localparam int ADC_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int VOLT_W    = 19;
  localparam int PCT_W     = 7;
  localparam int LEVEL_W   = 16;

  // reciprocal divider geometry: (avg * gain) * 275 is 37 bits, its top 27 bits
  // are divided once the factor 1024 of the denominator is shifted out
  localparam int SCALE_PRE_SHIFT   = 10;
  localparam int DIVD_W            = 27;
  localparam int DIVQ_W            = 19;
  localparam int RECIP_W           = 28;
  localparam int DPROD_W           = DIVD_W + RECIP_W;
  // reciprocals are scaled by 2^25 for the burst average and 2^36 for the scale
  localparam int RECIP_SHIFT_AVG   = 25;
  localparam int RECIP_SHIFT_SCALE = 36;

  // multiplier operand and result widths
  localparam int MUL_A_W   = 28;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd16384;
  // 66000 / (4095 * 16384) reduced by 240: 275 / 279552, and 279552 = 273 * 1024
  localparam logic [MUL_B_W-1:0] SCALE_NUM    = 16'd275;
  // ceil(2^36 / 273), exact for every dividend below 2^27
  localparam logic [RECIP_W-1:0] RECIP_SCALE  = 28'd251719696;
  localparam logic [VOLT_W-1:0]  VOLT_CLAMP   = 19'd264000;
  localparam logic [VOLT_W-1:0]  VOLT_EMPTY   = 19'd30000;
  localparam logic [PCT_W-1:0]   PCT_TOP      = 7'd100;
  localparam logic [PCT_W-1:0]   PCT_BOTTOM   = 7'd1;
  localparam logic [PCT_W-1:0]   PCT_NONE     = 7'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_GO,
    S_AVG_WAIT,
    S_MUL_GAIN,
    S_MUL_SCALE,
    S_SCALE_GO,
    S_SCALE_WAIT,
    S_SEARCH_GO,
    S_SEARCH_WAIT,
    S_DELIVER
  } bvg_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // voltage in 0.1 mV at which each charge percentage starts
  function automatic logic [LEVEL_W-1:0] level_of(input logic [PCT_W-1:0] idx);
    logic [LEVEL_W-1:0] lvl;
    unique case (idx)
      7'd0:   lvl = 16'd30000;
      7'd1:   lvl = 16'd31097;  7'd2:   lvl = 16'd31966;  7'd3:   lvl = 16'd32626;
      7'd4:   lvl = 16'd33495;  7'd5:   lvl = 16'd33891;  7'd6:   lvl = 16'd34144;
      7'd7:   lvl = 16'd34265;  7'd8:   lvl = 16'd34507;  7'd9:   lvl = 16'd34595;
      7'd10:  lvl = 16'd34727;  7'd11:  lvl = 16'd34815;  7'd12:  lvl = 16'd34848;
      7'd13:  lvl = 16'd34925;  7'd14:  lvl = 16'd34969;  7'd15:  lvl = 16'd35046;
      7'd16:  lvl = 16'd35101;  7'd17:  lvl = 16'd35244;  7'd18:  lvl = 16'd35398;
      7'd19:  lvl = 16'd35475;  7'd20:  lvl = 16'd35607;  7'd21:  lvl = 16'd35706;
      7'd22:  lvl = 16'd35926;  7'd23:  lvl = 16'd36003;  7'd24:  lvl = 16'd36201;
      7'd25:  lvl = 16'd36256;  7'd26:  lvl = 16'd36432;  7'd27:  lvl = 16'd36553;
      7'd28:  lvl = 16'd36685;  7'd29:  lvl = 16'd36861;  7'd30:  lvl = 16'd36938;
      7'd31:  lvl = 16'd37081;  7'd32:  lvl = 16'd37147;  7'd33:  lvl = 16'd37345;
      7'd34:  lvl = 16'd37400;  7'd35:  lvl = 16'd37499;  7'd36:  lvl = 16'd37554;
      7'd37:  lvl = 16'd37609;  7'd38:  lvl = 16'd37642;  7'd39:  lvl = 16'd37675;
      7'd40:  lvl = 16'd37675;  7'd41:  lvl = 16'd37741;  7'd42:  lvl = 16'd37796;
      7'd43:  lvl = 16'd37818;  7'd44:  lvl = 16'd37873;  7'd45:  lvl = 16'd37917;
      7'd46:  lvl = 16'd37994;  7'd47:  lvl = 16'd38038;  7'd48:  lvl = 16'd38060;
      7'd49:  lvl = 16'd38093;  7'd50:  lvl = 16'd38115;  7'd51:  lvl = 16'd38159;
      7'd52:  lvl = 16'd38203;  7'd53:  lvl = 16'd38236;  7'd54:  lvl = 16'd38247;
      7'd55:  lvl = 16'd38258;  7'd56:  lvl = 16'd38269;  7'd57:  lvl = 16'd38302;
      7'd58:  lvl = 16'd38313;  7'd59:  lvl = 16'd38324;  7'd60:  lvl = 16'd38335;
      7'd61:  lvl = 16'd38357;  7'd62:  lvl = 16'd38412;  7'd63:  lvl = 16'd38478;
      7'd64:  lvl = 16'd38588;  7'd65:  lvl = 16'd38654;  7'd66:  lvl = 16'd38830;
      7'd67:  lvl = 16'd38907;  7'd68:  lvl = 16'd39028;  7'd69:  lvl = 16'd39072;
      7'd70:  lvl = 16'd39193;  7'd71:  lvl = 16'd39259;  7'd72:  lvl = 16'd39303;
      7'd73:  lvl = 16'd39479;  7'd74:  lvl = 16'd39512;  7'd75:  lvl = 16'd39611;
      7'd76:  lvl = 16'd39644;  7'd77:  lvl = 16'd39721;  7'd78:  lvl = 16'd39754;
      7'd79:  lvl = 16'd39765;  7'd80:  lvl = 16'd39809;  7'd81:  lvl = 16'd39831;
      7'd82:  lvl = 16'd39853;  7'd83:  lvl = 16'd39886;  7'd84:  lvl = 16'd39897;
      7'd85:  lvl = 16'd39919;  7'd86:  lvl = 16'd39930;  7'd87:  lvl = 16'd39952;
      7'd88:  lvl = 16'd39963;  7'd89:  lvl = 16'd39963;  7'd90:  lvl = 16'd39985;
      7'd91:  lvl = 16'd39996;  7'd92:  lvl = 16'd40029;  7'd93:  lvl = 16'd40040;
      7'd94:  lvl = 16'd40062;  7'd95:  lvl = 16'd40150;  7'd96:  lvl = 16'd40205;
      7'd97:  lvl = 16'd40249;  7'd98:  lvl = 16'd40359;  7'd99:  lvl = 16'd40403;
      7'd100: lvl = 16'd40500;
      default: lvl = 16'hFFFF;
    endcase
    return lvl;
  endfunction

endpackage

>>> rtl/bvg_divider.sv
// bvg_divider: division by a constant through a registered reciprocal multiply
// depends on bvg_pkg
module bvg_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bvg_pkg::DIVD_W-1:0]  dividend,
  input  logic [bvg_pkg::RECIP_W-1:0] recip,
  input  logic                        long_shift,
  output logic [bvg_pkg::DIVQ_W-1:0]  quotient,
  output bvg_pkg::unit_stat_t         stat
);
  import bvg_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DIVD_W-1:0]  dvd_r;
  logic [RECIP_W-1:0] rcp_r;
  logic               long_r;
  logic [DPROD_W-1:0] prod_r, prod_nxt;

  // operands are captured on start; the product is taken in the next cycle unless start repeats
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = DPROD_W'(dvd_r) * DPROD_W'(rcp_r);
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (start) begin
      dvd_r  <= dividend;
      rcp_r  <= recip;
      long_r <= long_shift;
    end
  end

  // drop the reciprocal's scaling
  assign quotient  = long_r ? prod_r[RECIP_SHIFT_SCALE +: DIVQ_W]
                            : prod_r[RECIP_SHIFT_AVG +: DIVQ_W];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done together");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |=> done_r && !busy_r)
    else $error("divider did not finish after one step");
`endif

endmodule

>>> rtl/bvg_level_search.sv
// bvg_level_search: serial downward search of the charge level table
// depends on bvg_pkg
module bvg_level_search (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bvg_pkg::VOLT_W-1:0] volts,
  output logic [bvg_pkg::PCT_W-1:0]  percent,
  output bvg_pkg::unit_stat_t       stat
);
  import bvg_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PCT_W-1:0]  idx_r, idx_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [VOLT_W-1:0] volts_r;
  logic              hit;

  assign hit = volts_r >= VOLT_W'(level_of(idx_r));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    pct_nxt  = pct_r;
    if (start) begin
      if (volts <= VOLT_EMPTY) begin
        pct_nxt  = PCT_NONE;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        idx_nxt  = PCT_TOP;
      end
    end else if (busy_r) begin
      if (hit) begin
        pct_nxt  = idx_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (idx_r == PCT_BOTTOM) begin
        pct_nxt  = PCT_NONE;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pct_r <= pct_nxt;
    if (start) begin
      volts_r <= volts;
    end
  end

  assign percent   = pct_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r >= PCT_BOTTOM) && (idx_r <= PCT_TOP))
    else $error("search index out of table range");
  a_found_reaches: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && (pct_r != PCT_NONE) |-> volts_r >= VOLT_W'(level_of(pct_r)))
    else $error("reported level above voltage");
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r || $past(start))
    else $error("search done repeated without start");
`endif

endmodule

>>> rtl/battery_voltage_gauge.sv
// battery_voltage_gauge: burst averaging, gain scaling and charge lookup, top level
// depends on bvg_pkg, bvg_divider and bvg_level_search
// a sample not ending a burst is taken while idle; the sample ending a burst holds
// input off until its result is loaded for out_valid, past the 0 to 100 table search
// steps (none at or below empty); a waiting result holds the next burst end
// reset (rst_n, synchronous) clears sums and count and sets the gain to 1.0
module battery_voltage_gauge #(
  parameter int BURST_LENGTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input transaction: one adc sample
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bvg_pkg::ADC_W-1:0]   in_adc_sample,
  // result transaction: one per completed burst
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bvg_pkg::VOLT_W-1:0]  out_voltage_tenth_mv,
  output logic [bvg_pkg::PCT_W-1:0]   out_charge_percent,
  // correction gain register, unsigned q2.14
  input  logic                        cfg_wr_en,
  input  logic [bvg_pkg::GAIN_W-1:0]  cfg_wr_data
);
  import bvg_pkg::*;

  // burst bookkeeping widths
  localparam int CNT_W = (BURST_LENGTH > 1) ? $clog2(BURST_LENGTH) : 1;
  localparam int SUM_W = ADC_W + $clog2(BURST_LENGTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BURST_LENGTH - 1);
  // ceil(2^25 / burst length), exact for any burst sum below 2^18
  localparam logic [RECIP_W-1:0] RECIP_AVG =
    RECIP_W'(((1 << RECIP_SHIFT_AVG) + BURST_LENGTH - 1) / BURST_LENGTH);

  bvg_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [GAIN_W-1:0] gain_r;
  logic [ADC_W-1:0]  avg_r;
  logic [MUL_P_W-1:0] mul_r;
  logic [VOLT_W-1:0] volts_r;
  logic [VOLT_W-1:0] out_volts_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic              out_valid_r;

  logic              in_fire;
  logic              burst_end;
  logic              load_out;

  // shared multiplier operands
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // divider hookup
  logic               div_start;
  logic [DIVD_W-1:0]  div_dividend;
  logic [RECIP_W-1:0] div_recip;
  logic               div_long;
  logic [DIVQ_W-1:0]  div_quotient;
  unit_stat_t         div_stat;

  // table search hookup
  logic               srch_start;
  logic [PCT_W-1:0]   srch_percent;
  unit_stat_t         srch_stat;

  assign in_fire   = in_valid && in_ready;
  assign burst_end = in_fire && (cnt_r == CNT_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:        if (burst_end) state_nxt = S_AVG_GO;
      S_AVG_GO:      state_nxt = S_AVG_WAIT;
      S_AVG_WAIT:    if (div_stat.done) state_nxt = S_MUL_GAIN;
      S_MUL_GAIN:    state_nxt = S_MUL_SCALE;
      S_MUL_SCALE:   state_nxt = S_SCALE_GO;
      S_SCALE_GO:    state_nxt = S_SCALE_WAIT;
      S_SCALE_WAIT:  if (div_stat.done) state_nxt = S_SEARCH_GO;
      S_SEARCH_GO:   state_nxt = S_SEARCH_WAIT;
      S_SEARCH_WAIT: if (srch_stat.done) state_nxt = S_DELIVER;
      S_DELIVER:     if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:       state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    srch_start   = 1'b0;
    load_out     = 1'b0;
    div_dividend = DIVD_W'(sum_r);
    div_recip    = RECIP_AVG;
    div_long     = 1'b0;
    mul_a        = MUL_A_W'(avg_r);
    mul_b        = gain_r;
    unique case (state_r)
      S_IDLE:      in_ready = 1'b1;
      S_AVG_GO:    div_start = 1'b1;
      S_MUL_SCALE: begin
        mul_a = mul_r[MUL_A_W-1:0];
        mul_b = SCALE_NUM;
      end
      // the factor 1024 of the denominator goes by a shift, 273 by reciprocal
      S_SCALE_GO: begin
        div_start    = 1'b1;
        div_dividend = mul_r[SCALE_PRE_SHIFT +: DIVD_W];
        div_recip    = RECIP_SCALE;
        div_long     = 1'b1;
      end
      S_SEARCH_GO: srch_start = 1'b1;
      S_DELIVER:   load_out = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      // accumulate; the last sample leaves the full sum for the divider
      if (in_fire) begin
        sum_r <= sum_r + SUM_W'(in_adc_sample);
        cnt_r <= burst_end ? '0 : cnt_r + 1'b1;
      end else if (state_r == S_AVG_WAIT) begin
        sum_r <= '0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_AVG_WAIT && div_stat.done) begin
      avg_r <= div_quotient[ADC_W-1:0];
    end
    // one multiplier: avg * gain, then that product * 275
    if (state_r == S_MUL_GAIN || state_r == S_MUL_SCALE) begin
      mul_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end
    if (state_r == S_SCALE_WAIT && div_stat.done) begin
      volts_r <= (div_quotient > VOLT_CLAMP) ? VOLT_CLAMP : div_quotient;
    end
    if (load_out) begin
      out_volts_r <= volts_r;
      out_pct_r   <= srch_percent;
    end
  end

  bvg_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend   (div_dividend),
    .recip      (div_recip),
    .long_shift (div_long),
    .quotient   (div_quotient),
    .stat       (div_stat)
  );

  bvg_level_search u_srch (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (srch_start),
    .volts   (volts_r),
    .percent (srch_percent),
    .stat    (srch_stat)
  );

  assign out_valid            = out_valid_r;
  assign out_voltage_tenth_mv = out_volts_r;
  assign out_charge_percent   = out_pct_r;

`ifndef NO_ASSERTIONS
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    burst_end |=> !in_ready)
    else $error("sample taken while burst is being processed");
  a_volt_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_volts_r <= VOLT_CLAMP)
    else $error("voltage above clamp");
  a_pct_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_pct_r != PCT_NONE) |-> out_volts_r > VOLT_EMPTY)
    else $error("nonzero charge at or below empty voltage");
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pct_r <= PCT_TOP)
    else $error("charge above full");
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy && !srch_stat.busy)
    else $error("unit running while sequencer idle");
`endif

endmodule
